@@ rtl/bsr_pkg.sv @@
package bsr_pkg;

  // Operation codes carried in the op field of an input request.
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_GET  = 3'd1;
  localparam logic [2:0] OP_PEEK = 3'd2;
  localparam logic [2:0] OP_SKIP = 3'd3;
  localparam logic [2:0] OP_HUNT = 3'd4;
  localparam logic [2:0] OP_EOS  = 3'd5;

  // Status codes reported with every result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  // Field widths of the two channels.
  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int LEFT_W   = 7;

  // The start code prefix 00 00 01 as one 24-bit word.
  localparam logic [23:0] START_PREFIX = 24'h000001;

endpackage

@@ rtl/bsr_item_if.sv @@
interface bsr_item_if;
  logic                          valid;
  logic                          ready;
  logic [bsr_pkg::OP_W-1:0]      op;
  logic [bsr_pkg::BYTE_W-1:0]    byte_in;
  logic [bsr_pkg::COUNT_W-1:0]   bit_count;

  modport source (output valid, output op, output byte_in, output bit_count, input ready);
  modport sink   (input valid, input op, input byte_in, input bit_count, output ready);
endinterface

@@ rtl/bsr_result_if.sv @@
interface bsr_result_if;
  logic                          valid;
  logic                          ready;
  logic [bsr_pkg::VALUE_W-1:0]   bits_value;
  logic [bsr_pkg::STATUS_W-1:0]  status;
  logic [bsr_pkg::LEFT_W-1:0]    bits_left;

  modport source (output valid, output bits_value, output status, output bits_left, input ready);
  modport sink   (input valid, input bits_value, input status, input bits_left, output ready);
endinterface

@@ rtl/bsr_start_scan.sv @@
// Parallel search for the first 00 00 01 prefix among the held bytes.
module bsr_start_scan #(
  parameter int BUFFER_BITS = 64
) (
  input  logic [BUFFER_BITS-1:0]               buffer,
  input  logic [$clog2(BUFFER_BITS+1)-1:0]     occ,
  output logic                                 found,
  output logic [$clog2(BUFFER_BITS+1)-1:0]     occ_after
);
  localparam int OCC_W   = $clog2(BUFFER_BITS+1);
  localparam int NBYTES  = BUFFER_BITS / 8;
  localparam int NWIN    = NBYTES - 2;
  localparam int WIN_IDX = $clog2(NWIN);

  logic [NWIN-1:0]    match;
  logic [WIN_IDX-1:0] best;

  // A window is byte aligned from the newest byte; it counts only if it lies
  // entirely inside the held bits. The oldest matching window wins.
  always_comb begin
    best = '0;
    for (int b = 0; b < NWIN; b++) begin
      match[b] = (buffer[8*b +: 24] == bsr_pkg::START_PREFIX) &&
                 (occ >= OCC_W'(8*(b+3)));
      if (match[b]) begin
        best = WIN_IDX'(b);
      end
    end
  end

  assign found = |match;

  // Without a match the scan stops once fewer than three bytes remain.
  always_comb begin
    if (found) begin
      occ_after = OCC_W'((32'(best) + 32'd3) * 32'd8);
    end else if (occ >= OCC_W'(16)) begin
      occ_after = OCC_W'(16);
    end else begin
      occ_after = occ;
    end
  end
endmodule

@@ rtl/bitstream_reader_start_code_unit.sv @@
// An accepted request is held in the input register until the result register can load;
// its result is then registered and offered (input register, then result register).
// Throughput: one request per cycle while the result is not stalled; the buffer and occupancy
// update closes a feedback loop through the shifter and start-code scan, and that loop sets the rate.
// Reset (synchronous, active high) empties the buffer, ends any hunt and clears the valid bits
// of both pipeline registers.
module bitstream_reader_start_code_unit #(
  parameter int BUFFER_BITS = 64,
  parameter int MAX_REQUEST = 32
) (
  input  logic          clk,
  input  logic          rst,
  bsr_item_if.sink      item,
  bsr_result_if.source  result
);
  localparam int OCC_W = $clog2(BUFFER_BITS+1);
  localparam int REQ_W = $clog2(MAX_REQUEST+1);
  localparam int WIDE  = BUFFER_BITS + MAX_REQUEST;

  // Input register.
  logic                          s1_valid;
  logic [bsr_pkg::OP_W-1:0]      s1_op;
  logic [bsr_pkg::BYTE_W-1:0]    s1_byte;
  logic [bsr_pkg::COUNT_W-1:0]   s1_count;

  // Reader state.
  logic [BUFFER_BITS-1:0] buffer, buffer_next;
  logic [OCC_W-1:0]       occ, occ_next;
  logic                   hunting, hunting_next;

  logic can_load, advance, accept;

  assign can_load   = !result.valid || result.ready;
  assign advance    = s1_valid && can_load;
  assign item.ready = !s1_valid || can_load;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= item.op;
      s1_byte  <= item.byte_in;
      s1_count <= item.bit_count;
    end
  end

  // Request size, saturated to the largest request.
  logic [REQ_W-1:0] n;
  logic [OCC_W-1:0] n_ext;
  assign n = (s1_count > bsr_pkg::COUNT_W'(MAX_REQUEST)) ? REQ_W'(MAX_REQUEST)
                                                         : s1_count[REQ_W-1:0];
  assign n_ext = OCC_W'(n);

  // Head extraction: shift the held bits so the requested field ends at bit zero.
  logic                   is_short;
  logic [WIDE-1:0]        ext, shifted;
  logic [MAX_REQUEST-1:0] req_mask, head_value;

  assign is_short = n_ext > occ;
  assign ext      = WIDE'(buffer);
  assign shifted  = is_short ? (ext << (n_ext - occ)) : (ext >> (occ - n_ext));
  assign req_mask = ~({MAX_REQUEST{1'b1}} << n);
  assign head_value = shifted[MAX_REQUEST-1:0] & req_mask;

  // Push path and start-code scan.
  logic                   push_ok;
  logic [BUFFER_BITS-1:0] push_buffer, scan_buffer;
  logic [OCC_W-1:0]       push_occ, aligned_occ, scan_occ, scan_occ_after;
  logic                   scan_found;

  assign push_ok     = occ <= OCC_W'(BUFFER_BITS - 8);
  assign push_buffer = {buffer[BUFFER_BITS-9:0], s1_byte};
  assign push_occ    = occ + OCC_W'(8);
  assign aligned_occ = {occ[OCC_W-1:3], 3'b000};
  assign scan_buffer = (s1_op == bsr_pkg::OP_PUSH) ? push_buffer : buffer;
  assign scan_occ    = (s1_op == bsr_pkg::OP_PUSH) ? push_occ : aligned_occ;

  bsr_start_scan #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_scan (
    .buffer    (scan_buffer),
    .occ       (scan_occ),
    .found     (scan_found),
    .occ_after (scan_occ_after)
  );

  // Per-request state update and result.
  logic [BUFFER_BITS-1:0]        buffer_pre;
  logic [MAX_REQUEST-1:0]        value;
  logic [bsr_pkg::STATUS_W-1:0]  status;
  logic                          has_result;

  always_comb begin
    buffer_pre   = buffer;
    occ_next     = occ;
    hunting_next = hunting;
    value        = '0;
    status       = bsr_pkg::ST_OK;
    has_result   = 1'b1;
    case (s1_op)
      bsr_pkg::OP_PUSH: begin
        if (!push_ok) begin
          status = bsr_pkg::ST_OVERFLOW;
        end else begin
          buffer_pre = push_buffer;
          occ_next   = push_occ;
          if (hunting) begin
            occ_next = scan_occ_after;
            if (scan_found) begin
              hunting_next = 1'b0;
              status       = bsr_pkg::ST_FOUND;
            end else begin
              status = bsr_pkg::ST_BUSY;
            end
          end
        end
      end
      bsr_pkg::OP_GET, bsr_pkg::OP_PEEK, bsr_pkg::OP_SKIP: begin
        if (hunting) begin
          status = bsr_pkg::ST_BUSY;
        end else begin
          if (is_short) begin
            status = bsr_pkg::ST_SHORT;
          end
          if (s1_op != bsr_pkg::OP_SKIP) begin
            value = head_value;
          end
          if (s1_op != bsr_pkg::OP_PEEK) begin
            occ_next = is_short ? '0 : (occ - n_ext);
          end
        end
      end
      bsr_pkg::OP_HUNT: begin
        occ_next = scan_occ_after;
        if (scan_found) begin
          hunting_next = 1'b0;
          status       = bsr_pkg::ST_FOUND;
        end else begin
          hunting_next = 1'b1;
          status       = bsr_pkg::ST_BUSY;
        end
      end
      bsr_pkg::OP_EOS: begin
        if (hunting) begin
          hunting_next = 1'b0;
          occ_next     = '0;
          status       = bsr_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // Bits above the occupancy are always kept at zero.
  assign buffer_next = buffer_pre & ~({BUFFER_BITS{1'b1}} << occ_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer  <= '0;
      occ     <= '0;
      hunting <= 1'b0;
    end else if (advance) begin
      buffer  <= buffer_next;
      occ     <= occ_next;
      hunting <= hunting_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (can_load) begin
      result.valid <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.bits_value <= bsr_pkg::VALUE_W'(value);
      result.status     <= status;
      result.bits_left  <= bsr_pkg::LEFT_W'(occ_next);
    end
  end
endmodule

@@ rtl/bsr_checker.sv @@
module bsr_checker #(
  parameter int BUFFER_BITS = 64
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          valid,
  input logic                          ready,
  input logic [bsr_pkg::VALUE_W-1:0]   bits_value,
  input logic [bsr_pkg::STATUS_W-1:0]  status,
  input logic [bsr_pkg::LEFT_W-1:0]    bits_left
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(bits_value) && $stable(status) && $stable(bits_left))
    else $error("result changed while stalled");

  // The buffer never reports more bits than it can hold.
  assert property (@(posedge clk) disable iff (rst)
    valid |-> bits_left <= bsr_pkg::LEFT_W'(BUFFER_BITS))
    else $error("bits_left above buffer size");

  // A found start code sits byte aligned with at least three bytes held.
  assert property (@(posedge clk) disable iff (rst)
    valid && status == bsr_pkg::ST_FOUND |-> bits_left >= 7'd24 && bits_left[2:0] == 3'b000)
    else $error("start code found with bad occupancy");

  // A hunt still in progress leaves at most two whole bytes.
  assert property (@(posedge clk) disable iff (rst)
    valid && status == bsr_pkg::ST_BUSY |-> bits_left <= 7'd16 && bits_left[2:0] == 3'b000)
    else $error("busy hunt with bad occupancy");

  // Only a completed or short read carries data.
  assert property (@(posedge clk) disable iff (rst)
    valid && bits_value != '0 |-> status == bsr_pkg::ST_OK || status == bsr_pkg::ST_SHORT)
    else $error("data returned with unexpected status");

endmodule

bind bitstream_reader_start_code_unit bsr_checker #(
  .BUFFER_BITS (BUFFER_BITS)
) u_bsr_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (result.valid),
  .ready      (result.ready),
  .bits_value (result.bits_value),
  .status     (result.status),
  .bits_left  (result.bits_left)
);

@@ verif/bitstream_reader_start_code_unit_tb.sv @@
`timescale 1ns / 100ps

module bitstream_reader_start_code_unit_tb;

  localparam int BUFFER_CAP = 64;
  localparam int MAX_BITS = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_IDLE = 18;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP = 60;

  // Op codes that the block ignores without giving a result.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [bsr_pkg::VALUE_W-1:0]  bits_value;
    logic [bsr_pkg::STATUS_W-1:0] status;
    logic [bsr_pkg::LEFT_W-1:0]   bits_left;
  } reader_result_t;

  logic clk;
  logic rst;

  bsr_item_if   item_ch ();
  bsr_result_if result_ch ();

  bitstream_reader_start_code_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Shadow copy of the reader state.
  logic [63:0] model_bits;
  int unsigned model_occupancy;
  bit          model_hunting;

  reader_result_t pending_results[$];

  int mismatches;
  int requests_sent;
  int results_checked;
  int cycle_count;
  int hold_left;
  bit sender_gaps;
  bit receiver_gaps;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // The long receiver hold-off counts itself down here.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic logic [63:0] ones_below(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Drops whole head bytes until 00 00 01 leads or fewer than three bytes are held.
  function automatic bit align_to_prefix();
    logic [63:0] head;
    while (model_occupancy >= 24) begin
      head = model_bits >> (model_occupancy - 24);
      if (head[23:0] == bsr_pkg::START_PREFIX) return 1'b1;
      model_occupancy = model_occupancy - 8;
    end
    return 1'b0;
  endfunction

  // Takes n head bits without consuming them; short reads are padded at the right.
  function automatic logic [63:0] head_bits(input int unsigned n, output bit was_short);
    logic [63:0] held;
    held = model_bits & ones_below(model_occupancy);
    if (n <= model_occupancy) begin
      was_short = 1'b0;
      return (held >> (model_occupancy - n)) & ones_below(n);
    end
    was_short = 1'b1;
    return (held << (n - model_occupancy)) & ones_below(n);
  endfunction

  // Advances the shadow reader by one request and queues the result it gives.
  task automatic predict_request(input logic [2:0] op, input logic [7:0] byte_val,
                                 input logic [5:0] count);
    reader_result_t r;
    int unsigned n;
    bit was_short;
    logic [63:0] field;
    r = '0;
    r.status = bsr_pkg::ST_OK;
    n = (count > MAX_BITS) ? MAX_BITS : count;
    case (op)
      bsr_pkg::OP_PUSH: begin
        if (model_occupancy + 8 > BUFFER_CAP) begin
          r.status = bsr_pkg::ST_OVERFLOW;
        end else begin
          model_bits = (model_bits << 8) | {56'd0, byte_val};
          model_occupancy = model_occupancy + 8;
          if (model_hunting) begin
            if (align_to_prefix()) begin
              model_hunting = 1'b0;
              r.status = bsr_pkg::ST_FOUND;
            end else begin
              r.status = bsr_pkg::ST_BUSY;
            end
          end
        end
      end
      bsr_pkg::OP_GET, bsr_pkg::OP_PEEK, bsr_pkg::OP_SKIP: begin
        if (model_hunting) begin
          r.status = bsr_pkg::ST_BUSY;
        end else if (n != 0) begin
          field = head_bits(n, was_short);
          if (was_short) r.status = bsr_pkg::ST_SHORT;
          if (op != bsr_pkg::OP_SKIP) r.bits_value = field[31:0];
          if (op != bsr_pkg::OP_PEEK) model_occupancy = was_short ? 0 : model_occupancy - n;
        end
      end
      bsr_pkg::OP_HUNT: begin
        model_occupancy = model_occupancy - (model_occupancy % 8);
        if (align_to_prefix()) begin
          model_hunting = 1'b0;
          r.status = bsr_pkg::ST_FOUND;
        end else begin
          model_hunting = 1'b1;
          r.status = bsr_pkg::ST_BUSY;
        end
      end
      bsr_pkg::OP_EOS: begin
        if (model_hunting) begin
          model_hunting = 1'b0;
          model_occupancy = 0;
          r.status = bsr_pkg::ST_NOT_FOUND;
        end
      end
      default: return;
    endcase
    model_bits = model_bits & ones_below(model_occupancy);
    r.bits_left = model_occupancy[bsr_pkg::LEFT_W-1:0];
    pending_results.push_back(r);
  endtask

  // Offers one request, after a random gap if sender gaps are on, and predicts it once it is taken.
  task automatic send_request(input logic [2:0] op, input logic [7:0] byte_val,
                              input logic [5:0] count);
    int gap;
    gap = sender_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.op        <= op;
    item_ch.byte_in   <= byte_val;
    item_ch.bit_count <= count;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    requests_sent++;
    predict_request(op, byte_val, count);
  endtask

  // Result side: checks every accepted result and draws its own stalls.
  initial begin : result_sink
    int stall_left;
    reader_result_t want;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h status %0d left %0d",
                                    result_ch.bits_value, result_ch.status,
                                    result_ch.bits_left));
        end else begin
          want = pending_results.pop_front();
          if (result_ch.bits_value !== want.bits_value)
            report_mismatch($sformatf("bits_value %h, expected %h",
                                      result_ch.bits_value, want.bits_value));
          if (result_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result_ch.status, want.status));
          if (result_ch.bits_left !== want.bits_left)
            report_mismatch($sformatf("bits_left %0d, expected %0d",
                                      result_ch.bits_left, want.bits_left));
        end
        stall_left = receiver_gaps ? $urandom_range(0, MAX_IDLE) : 0;
      end
      result_ch.ready <= !rst && stall_left == 0 && hold_left == 0;
      if (stall_left > 0) stall_left--;
    end
  end

  // Reads from an empty buffer and a zero-length peek.
  task automatic test_empty_buffer();
    send_request(bsr_pkg::OP_GET, 8'h00, 6'd8);
    send_request(bsr_pkg::OP_PEEK, 8'hff, 6'd0);
  endtask

  // Aligned and unaligned reads, then a saturated get that runs short.
  task automatic test_field_reads();
    send_request(bsr_pkg::OP_PUSH, 8'ha5, 6'd0);
    send_request(bsr_pkg::OP_PUSH, 8'h3c, 6'd63);
    send_request(bsr_pkg::OP_PUSH, 8'hff, 6'd0);
    send_request(bsr_pkg::OP_PEEK, 8'h00, 6'd12);
    send_request(bsr_pkg::OP_GET, 8'h00, 6'd5);
    send_request(bsr_pkg::OP_GET, 8'h00, 6'd63);
  endtask

  // Fills the buffer, overflows it, then hunts past a partial byte.
  task automatic test_full_buffer_and_hunt();
    logic [7:0] fill[8];
    fill = '{8'hff, 8'h00, 8'h00, 8'h01, 8'h80, 8'h7f, 8'h00, 8'hff};
    foreach (fill[i]) send_request(bsr_pkg::OP_PUSH, fill[i], 6'd0);
    send_request(bsr_pkg::OP_PUSH, 8'h55, 6'd0);
    send_request(bsr_pkg::OP_GET, 8'h00, 6'd3);
    send_request(bsr_pkg::OP_HUNT, 8'h00, 6'd0);
    send_request(bsr_pkg::OP_SKIP, 8'h00, 6'd40);
    send_request(bsr_pkg::OP_HUNT, 8'h00, 6'd0);
    send_request(bsr_pkg::OP_GET, 8'h00, 6'd8);
  endtask

  // End of stream with and without a hunt, and the ignored op codes.
  task automatic test_end_of_stream();
    send_request(bsr_pkg::OP_EOS, 8'h00, 6'd0);
    send_request(OP_SPARE_A, 8'h12, 6'd9);
    send_request(OP_SPARE_B, 8'hed, 6'd54);
    send_request(bsr_pkg::OP_EOS, 8'hff, 6'd63);
  endtask

  // Mostly byte streams with embedded start codes, mixed with reads, hunts, end of stream and ignored op codes.
  task automatic test_random_traffic(input int request_total, input bit send_gaps,
                                     input bit recv_gaps);
    int sent;
    int pick;
    logic [7:0] b;
    logic [5:0] c;
    sender_gaps = send_gaps;
    receiver_gaps = recv_gaps;
    sent = 0;
    while (sent < request_total) begin
      pick = $urandom_range(0, 99);
      c = 6'($urandom);
      if (pick < 12) begin
        send_request(bsr_pkg::OP_PUSH, bsr_pkg::START_PREFIX[23:16], c);
        send_request(bsr_pkg::OP_PUSH, bsr_pkg::START_PREFIX[15:8], 6'($urandom));
        send_request(bsr_pkg::OP_PUSH, bsr_pkg::START_PREFIX[7:0], 6'($urandom));
        send_request(bsr_pkg::OP_PUSH, 8'($urandom), 6'($urandom));
        sent += 4;
      end else if (pick < 45) begin
        b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        send_request(bsr_pkg::OP_PUSH, b, c);
        sent++;
      end else if (pick < 80) begin
        if ($urandom_range(0, 7) != 0) c = 6'($urandom_range(0, MAX_BITS));
        send_request(3'($urandom_range(bsr_pkg::OP_GET, bsr_pkg::OP_SKIP)), 8'($urandom), c);
        sent++;
      end else if (pick < 90) begin
        send_request(bsr_pkg::OP_HUNT, 8'($urandom), c);
        sent++;
      end else if (pick < 96) begin
        send_request(bsr_pkg::OP_EOS, 8'($urandom), c);
        sent++;
      end else begin
        send_request(3'($urandom_range(OP_SPARE_A, OP_SPARE_B)), 8'($urandom), c);
      end
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming back to back.
  task automatic test_backpressure();
    hold_left <= 300;
    test_random_traffic(100, 1'b0, 1'b0);
  endtask

  initial begin
    mismatches = 0;
    requests_sent = 0;
    results_checked = 0;
    cycle_count = 0;
    hold_left = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    model_bits = '0;
    model_occupancy = 0;
    model_hunting = 1'b0;
    rst <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.op        <= bsr_pkg::OP_PUSH;
    item_ch.byte_in   <= '0;
    item_ch.bit_count <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_buffer();
    test_field_reads();
    test_full_buffer_and_hunt();
    test_end_of_stream();
    test_random_traffic(350, 1'b1, 1'b1);
    test_random_traffic(200, 1'b0, 1'b0);
    test_random_traffic(180, 1'b1, 1'b0);
    test_random_traffic(180, 1'b0, 1'b1);
    test_backpressure();
    item_ch.valid <= 1'b0;

    // Let the pipeline drain, then watch a little longer for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results over %0d cycles.",
             requests_sent, results_checked, cycle_count);
    $display("Covered pushes, reads, hunts, end of stream, ignored ops, stalls and a long hold.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
